// ===== design/ocs_pkg.sv =====
// ----------------------------------------------------------------------------
// ocs_pkg
// shared stage, side, operation codes and state/result types of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ocs_pkg;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLOSE    = 4'd1;
    localparam logic [3:0] ST_OPEN     = 4'd2;
    localparam logic [3:0] ST_ENABLE   = 4'd3;
    localparam logic [3:0] ST_DISC     = 4'd4;
    localparam logic [3:0] ST_WAITFLIP = 4'd5;
    localparam logic [3:0] ST_PLANNER  = 4'd6;
    localparam logic [3:0] ST_REMOTE   = 4'd7;
    localparam logic [3:0] ST_REGRIP   = 4'd8;
    localparam logic [3:0] ST_REOPEN   = 4'd9;
    localparam logic [3:0] ST_CLEAR    = 4'd10;
    localparam logic [3:0] ST_MANUAL   = 4'd11;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_CLOSE   = 3'd1;
    localparam logic [2:0] OP_DISC    = 3'd2;
    localparam logic [2:0] OP_PLANNER = 3'd3;
    localparam logic [2:0] OP_REGRIP  = 3'd4;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic [1:0] DRIVE_FWD = 2'd1;
    localparam logic [1:0] DRIVE_REV = 2'd2;

    localparam logic [1:0] DISC_DONE = 2'd1;
    localparam logic [1:0] DISC_FAIL = 2'd2;

    localparam logic [1:0] PLAN_DONE     = 2'd1;
    localparam logic [1:0] PLAN_RELEASED = 2'd2;
    localparam logic [1:0] PLAN_WATCHDOG = 2'd3;

    localparam logic [1:0] PACT_NONE   = 2'd0;
    localparam logic [1:0] PACT_START  = 2'd1;
    localparam logic [1:0] PACT_SAFETY = 2'd2;
    localparam logic [1:0] PACT_MANUAL = 2'd3;

    localparam logic [1:0] NOTE_NONE     = 2'd0;
    localparam logic [1:0] NOTE_WAITFLIP = 2'd1;
    localparam logic [1:0] NOTE_DISCFAIL = 2'd2;
    localparam logic [1:0] NOTE_REGRIP   = 2'd3;

    localparam logic [2:0] REG_GRIP_WAIT  = 3'd0;
    localparam logic [2:0] REG_REGRIP_TO  = 3'd1;
    localparam logic [2:0] REG_REGRIP_MAX = 3'd2;
    localparam logic [2:0] REG_LEFT_GRAV  = 3'd3;
    localparam logic [2:0] REG_RIGHT_GRAV = 3'd4;

    localparam int RESULT_BITS = 24;

    typedef struct packed {
        logic [3:0] stage;
        logic [1:0] side;
        logic [1:0] first_side;
        logic [2:0] failure_kind;
        logic [7:0] retry_left;
        logic [7:0] retry_right;
        logic       grip_low_seen;
        logic [1:0] latched_gravity;
    } seq_state_t;

    typedef struct packed {
        logic       start_disconnect;
        logic       reset_disconnect;
        logic [1:0] planner_cmd;
        logic       reset_remote_session;
        logic       start_remote_session;
        logic       wheel_travel_clear;
        logic [1:0] notice;
    } actions_t;

    typedef struct packed {
        logic [31:0] grip_wait_time;
        logic [31:0] regrip_timeout;
        logic [7:0]  regrip_max;
        logic [1:0]  left_gravity_mode;
        logic [1:0]  right_gravity_mode;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/obstacle_crossing_sequencer.sv =====
// an input transfer is held in the input register, then its result in the result
// register; one update per cycle while the downstream does not stall, set by the single
// stage decision between the two registers
// reset: synchronous, active low; clears the sequencer state, the edge detector,
// both valid flags and reloads the configuration defaults
// ----------------------------------------------------------------------------
// obstacle_crossing_sequencer
// two-side obstacle crossing sequencer with twelve stages, streaming in and out
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_crossing_sequencer #(
    parameter int TIME_BITS = 32,
    parameter int SEQ_BITS  = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration writes
    input  wire         cfg_wr_en,
    input  wire [2:0]   cfg_index,
    input  wire [31:0]  cfg_wdata,
    // update items
    input  wire         s_tvalid,
    output logic        s_tready,
    // from bit 0: now_time, trigger_level, rise_sequence, fall_sequence,
    // sequences_valid, safety hold, traversing, grip closed,
    // drive_request, request_flags, disconnect_outcome, planner_outcome
    input  wire [((TIME_BITS+2*SEQ_BITS+14+7)/8)*8-1:0] s_tdata,
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    // from bit 0: start_disconnect, reset_disconnect, planner command,
    // reset_remote_session, start_remote_session, wheel travel clear, notice,
    // stage_now, side_now, gravity_mode, failed_op
    output logic [ocs_pkg::RESULT_BITS-1:0] m_tdata
);

    localparam int IN_W = ((TIME_BITS + 2 * SEQ_BITS + 14 + 7) / 8) * 8;
    localparam int B    = TIME_BITS + 2 * SEQ_BITS + 1;  // sequences_valid bit

    // configuration registers
    ocs_pkg::cfg_t cfg_reg;

    // input register
    logic            in_valid_reg;
    logic [IN_W-1:0] in_data_reg;

    // sequencer state
    ocs_pkg::seq_state_t  st_reg;
    ocs_pkg::seq_state_t  st_next;
    logic [TIME_BITS-1:0] wait_start_reg;
    logic [TIME_BITS-1:0] wait_start_next;
    logic                 edges_ready_reg;
    logic                 prev_trigger_reg;
    logic [SEQ_BITS-1:0]  prev_rise_reg;
    logic [SEQ_BITS-1:0]  prev_fall_reg;

    // result register
    logic                            m_valid_reg;
    logic [ocs_pkg::RESULT_BITS-1:0] m_data_reg;
    ocs_pkg::actions_t               acts;

    logic advance;  // the held item moves into the result register

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // configuration port, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grip_wait_time     <= 32'd1000;
            cfg_reg.regrip_timeout     <= 32'd1000;
            cfg_reg.regrip_max         <= 8'd3;
            cfg_reg.left_gravity_mode  <= 2'd0;
            cfg_reg.right_gravity_mode <= 2'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ocs_pkg::REG_GRIP_WAIT:  cfg_reg.grip_wait_time     <= cfg_wdata;
                ocs_pkg::REG_REGRIP_TO:  cfg_reg.regrip_timeout     <= cfg_wdata;
                ocs_pkg::REG_REGRIP_MAX: cfg_reg.regrip_max         <= cfg_wdata[7:0];
                ocs_pkg::REG_LEFT_GRAV:  cfg_reg.left_gravity_mode  <= cfg_wdata[1:0];
                ocs_pkg::REG_RIGHT_GRAV: cfg_reg.right_gravity_mode <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // input register takes a transfer whenever it is empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    ocs_step #(
        .TIME_BITS(TIME_BITS),
        .SEQ_BITS (SEQ_BITS)
    ) u_step (
        .cfg               (cfg_reg),
        .st_cur            (st_reg),
        .wait_start_cur    (wait_start_reg),
        .edges_ready_cur   (edges_ready_reg),
        .prev_trigger_cur  (prev_trigger_reg),
        .prev_rise_cur     (prev_rise_reg),
        .prev_fall_cur     (prev_fall_reg),
        .now_time          (in_data_reg[TIME_BITS-1:0]),
        .trigger_level     (in_data_reg[TIME_BITS]),
        .rise_sequence     (in_data_reg[TIME_BITS+SEQ_BITS:TIME_BITS+1]),
        .fall_sequence     (in_data_reg[TIME_BITS+2*SEQ_BITS:TIME_BITS+SEQ_BITS+1]),
        .sequences_valid   (in_data_reg[B]),
        .safety_hold       (in_data_reg[B+1]),
        .traversing        (in_data_reg[B+2]),
        .grip_closed       (in_data_reg[B+3]),
        .drive_request     (in_data_reg[B+5:B+4]),
        .request_flags     (in_data_reg[B+8:B+6]),
        .disconnect_outcome(in_data_reg[B+10:B+9]),
        .planner_outcome   (in_data_reg[B+12:B+11]),
        .st_next           (st_next),
        .wait_start_next   (wait_start_next),
        .acts              (acts)
    );

    // state and edge detector move once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.stage           <= ocs_pkg::ST_IDLE;
            st_reg.side            <= ocs_pkg::SIDE_NONE;
            st_reg.first_side      <= ocs_pkg::SIDE_LEFT;
            st_reg.failure_kind    <= ocs_pkg::OP_NONE;
            st_reg.retry_left      <= 8'd0;
            st_reg.retry_right     <= 8'd0;
            st_reg.grip_low_seen   <= 1'b0;
            st_reg.latched_gravity <= 2'd0;
            wait_start_reg         <= '0;
            edges_ready_reg        <= 1'b0;
            prev_trigger_reg       <= 1'b0;
            prev_rise_reg          <= '0;
            prev_fall_reg          <= '0;
        end else if (advance) begin
            st_reg           <= st_next;
            wait_start_reg   <= wait_start_next;
            edges_ready_reg  <= 1'b1;
            prev_trigger_reg <= in_data_reg[TIME_BITS];
            prev_rise_reg    <= in_data_reg[TIME_BITS+SEQ_BITS:TIME_BITS+1];
            prev_fall_reg    <= in_data_reg[TIME_BITS+2*SEQ_BITS:TIME_BITS+SEQ_BITS+1];
        end
    end

    // result register, holds while the downstream stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {4'd0, st_next.failure_kind, st_next.latched_gravity, st_next.side,
                           st_next.stage, acts.notice, acts.wheel_travel_clear,
                           acts.start_remote_session, acts.reset_remote_session,
                           acts.planner_cmd, acts.reset_disconnect,
                           acts.start_disconnect};
        end
    end

`ifndef SYNTHESIS
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stage <= ocs_pkg::ST_MANUAL)
        else $error("stage register out of range");

    a_idle_no_side: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stage == ocs_pkg::ST_IDLE |-> st_reg.side == ocs_pkg::SIDE_NONE)
        else $error("idle stage with a side selected");

    a_fail_only_manual: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stage != ocs_pkg::ST_MANUAL |-> st_reg.failure_kind == ocs_pkg::OP_NONE)
        else $error("failure kind outside manual intervention");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending item lost while result stalled");
`endif

endmodule

`default_nettype wire

// ===== design/ocs_step.sv =====
// ----------------------------------------------------------------------------
// ocs_step
// one update of the crossing sequencer: edge detect and stage decision
// ----------------------------------------------------------------------------
`default_nettype none

module ocs_step #(
    parameter int TIME_BITS = 32,
    parameter int SEQ_BITS  = 16
) (
    input  wire ocs_pkg::cfg_t        cfg,
    input  wire ocs_pkg::seq_state_t  st_cur,
    input  wire [TIME_BITS-1:0]       wait_start_cur,
    input  wire                       edges_ready_cur,
    input  wire                       prev_trigger_cur,
    input  wire [SEQ_BITS-1:0]        prev_rise_cur,
    input  wire [SEQ_BITS-1:0]        prev_fall_cur,
    input  wire [TIME_BITS-1:0]       now_time,
    input  wire                       trigger_level,
    input  wire [SEQ_BITS-1:0]        rise_sequence,
    input  wire [SEQ_BITS-1:0]        fall_sequence,
    input  wire                       sequences_valid,
    input  wire                       safety_hold,
    input  wire                       traversing,
    input  wire                       grip_closed,
    input  wire [1:0]                 drive_request,
    input  wire [2:0]                 request_flags,
    input  wire [1:0]                 disconnect_outcome,
    input  wire [1:0]                 planner_outcome,
    output ocs_pkg::seq_state_t       st_next,
    output logic [TIME_BITS-1:0]      wait_start_next,
    output ocs_pkg::actions_t         acts
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] diff;
    logic                 grip_elapsed;
    logic                 regrip_elapsed;
    logic                 rise;
    logic                 fall;
    logic                 grip_event;
    logic [7:0]           cnt;
    logic [1:0]           opp;
    logic [2:0]           op;
    logic                 need_latch;

    assign diff           = now_time - wait_start_cur;
    assign grip_elapsed   = CW'(diff) >= CW'(cfg.grip_wait_time);
    assign regrip_elapsed = CW'(diff) >= CW'(cfg.regrip_timeout);

    assign rise = edges_ready_cur && ((!prev_trigger_cur && trigger_level) ||
                  (sequences_valid && rise_sequence != prev_rise_cur));
    assign fall = edges_ready_cur && ((prev_trigger_cur && !trigger_level) ||
                  (sequences_valid && fall_sequence != prev_fall_cur));

    always_comb begin
        st_next         = st_cur;
        wait_start_next = wait_start_cur;
        acts            = '0;
        grip_event      = 1'b0;
        cnt             = 8'd0;
        op              = st_cur.failure_kind;
        need_latch      = 1'b0;
        unique case (st_cur.side)
            ocs_pkg::SIDE_LEFT:  opp = ocs_pkg::SIDE_RIGHT;
            ocs_pkg::SIDE_RIGHT: opp = ocs_pkg::SIDE_LEFT;
            default:             opp = ocs_pkg::SIDE_NONE;
        endcase

        if (safety_hold) begin
            acts.reset_disconnect     = 1'b1;
            acts.planner_cmd          = ocs_pkg::PACT_SAFETY;
            acts.reset_remote_session = 1'b1;
            if (grip_closed) begin
                st_next.latched_gravity = 2'd0;
            end
            st_next.stage         = ocs_pkg::ST_IDLE;
            st_next.side          = ocs_pkg::SIDE_NONE;
            st_next.first_side    = ocs_pkg::SIDE_LEFT;
            st_next.failure_kind  = ocs_pkg::OP_NONE;
            st_next.retry_left    = 8'd0;
            st_next.retry_right   = 8'd0;
            st_next.grip_low_seen = 1'b0;
            wait_start_next       = '0;
        end else begin
            // gripper confirmation counts only after a low was seen
            if (st_cur.stage == ocs_pkg::ST_CLOSE || st_cur.stage == ocs_pkg::ST_REGRIP) begin
                if (!grip_closed) begin
                    st_next.grip_low_seen = 1'b1;
                end else if (st_cur.grip_low_seen) begin
                    st_next.grip_low_seen = 1'b0;
                    grip_event            = 1'b1;
                end
            end

            unique case (st_cur.stage)
                ocs_pkg::ST_IDLE: begin
                    if (request_flags[0] || (traversing && rise)) begin
                        st_next.retry_left   = 8'd0;
                        st_next.retry_right  = 8'd0;
                        st_next.failure_kind = ocs_pkg::OP_NONE;
                        if (drive_request == ocs_pkg::DRIVE_FWD ||
                            drive_request == ocs_pkg::DRIVE_REV) begin
                            st_next.first_side    = drive_request;
                            st_next.side          = drive_request;
                            st_next.grip_low_seen = 1'b0;
                            st_next.stage         = ocs_pkg::ST_OPEN;
                            wait_start_next       = now_time;
                        end else begin
                            st_next.first_side = ocs_pkg::SIDE_NONE;
                        end
                    end
                end
                ocs_pkg::ST_CLOSE: begin
                    if (grip_event) begin
                        st_next.side    = st_cur.first_side;
                        st_next.stage   = ocs_pkg::ST_OPEN;
                        wait_start_next = now_time;
                    end else if (grip_elapsed) begin
                        st_next.side                = st_cur.first_side;
                        st_next.stage               = ocs_pkg::ST_MANUAL;
                        st_next.failure_kind        = ocs_pkg::OP_CLOSE;
                        acts.reset_disconnect       = 1'b1;
                        acts.planner_cmd            = ocs_pkg::PACT_MANUAL;
                        acts.reset_remote_session   = 1'b1;
                    end
                end
                ocs_pkg::ST_OPEN: begin
                    if (grip_elapsed) begin
                        st_next.stage = ocs_pkg::ST_ENABLE;
                    end
                end
                ocs_pkg::ST_ENABLE: begin
                    st_next.stage         = ocs_pkg::ST_DISC;
                    acts.start_disconnect = 1'b1;
                end
                ocs_pkg::ST_DISC: begin
                    if (disconnect_outcome == ocs_pkg::DISC_DONE) begin
                        st_next.stage         = ocs_pkg::ST_WAITFLIP;
                        acts.reset_disconnect = 1'b1;
                        acts.notice           = ocs_pkg::NOTE_WAITFLIP;
                    end else if (disconnect_outcome == ocs_pkg::DISC_FAIL) begin
                        st_next.stage             = ocs_pkg::ST_MANUAL;
                        st_next.failure_kind      = ocs_pkg::OP_DISC;
                        acts.reset_disconnect     = 1'b1;
                        acts.planner_cmd          = ocs_pkg::PACT_MANUAL;
                        acts.reset_remote_session = 1'b1;
                        acts.notice               = ocs_pkg::NOTE_DISCFAIL;
                    end
                end
                ocs_pkg::ST_WAITFLIP: begin
                    if (request_flags[1]) begin
                        st_next.stage    = ocs_pkg::ST_PLANNER;
                        acts.planner_cmd = ocs_pkg::PACT_START;
                    end
                end
                ocs_pkg::ST_PLANNER: begin
                    if (planner_outcome == ocs_pkg::PLAN_DONE ||
                        planner_outcome == ocs_pkg::PLAN_RELEASED) begin
                        st_next.stage             = ocs_pkg::ST_REMOTE;
                        acts.reset_disconnect     = 1'b1;
                        acts.start_remote_session = 1'b1;
                    end else if (planner_outcome == ocs_pkg::PLAN_WATCHDOG) begin
                        st_next.stage             = ocs_pkg::ST_MANUAL;
                        st_next.failure_kind      = ocs_pkg::OP_PLANNER;
                        acts.reset_disconnect     = 1'b1;
                        acts.reset_remote_session = 1'b1;
                    end
                end
                ocs_pkg::ST_REMOTE: begin
                    if (request_flags[2]) begin
                        st_next.stage         = ocs_pkg::ST_REGRIP;
                        acts.notice           = ocs_pkg::NOTE_REGRIP;
                        wait_start_next       = now_time;
                        st_next.grip_low_seen = !grip_closed;
                    end
                end
                ocs_pkg::ST_REGRIP: begin
                    if (grip_event) begin
                        if (st_cur.side == ocs_pkg::SIDE_LEFT) begin
                            st_next.retry_left = 8'd0;
                        end
                        if (st_cur.side == ocs_pkg::SIDE_RIGHT) begin
                            st_next.retry_right = 8'd0;
                        end
                        if (st_cur.side == st_cur.first_side) begin
                            st_next.latched_gravity = 2'd0;
                            st_next.side            = opp;
                            st_next.stage           = ocs_pkg::ST_OPEN;
                            wait_start_next         = now_time;
                        end else begin
                            st_next.latched_gravity = 2'd0;
                            st_next.stage           = ocs_pkg::ST_CLEAR;
                            st_next.side            = ocs_pkg::SIDE_NONE;
                            acts.reset_disconnect   = 1'b1;
                            acts.wheel_travel_clear = 1'b1;
                        end
                    end else if (regrip_elapsed) begin
                        cnt = (st_cur.side == ocs_pkg::SIDE_RIGHT) ? st_cur.retry_right
                                                                   : st_cur.retry_left;
                        if (cnt != 8'hff) begin
                            cnt = cnt + 8'd1;
                        end
                        if (st_cur.side == ocs_pkg::SIDE_LEFT) begin
                            st_next.retry_left = cnt;
                        end
                        if (st_cur.side == ocs_pkg::SIDE_RIGHT) begin
                            st_next.retry_right = cnt;
                        end
                        if ((st_cur.side != ocs_pkg::SIDE_LEFT &&
                             st_cur.side != ocs_pkg::SIDE_RIGHT) ||
                            cnt >= cfg.regrip_max) begin
                            st_next.stage             = ocs_pkg::ST_MANUAL;
                            st_next.failure_kind      = ocs_pkg::OP_REGRIP;
                            acts.reset_disconnect     = 1'b1;
                            acts.planner_cmd          = ocs_pkg::PACT_MANUAL;
                            acts.reset_remote_session = 1'b1;
                        end else begin
                            st_next.stage   = ocs_pkg::ST_REOPEN;
                            wait_start_next = now_time;
                        end
                    end
                end
                ocs_pkg::ST_REOPEN: begin
                    if (grip_elapsed) begin
                        st_next.stage             = ocs_pkg::ST_REMOTE;
                        acts.reset_disconnect     = 1'b1;
                        acts.start_remote_session = 1'b1;
                    end
                end
                ocs_pkg::ST_CLEAR: begin
                    if (fall) begin
                        acts.reset_disconnect     = 1'b1;
                        acts.planner_cmd          = ocs_pkg::PACT_SAFETY;
                        acts.reset_remote_session = 1'b1;
                        if (grip_closed) begin
                            st_next.latched_gravity = 2'd0;
                        end
                        st_next.stage         = ocs_pkg::ST_IDLE;
                        st_next.side          = ocs_pkg::SIDE_NONE;
                        st_next.first_side    = ocs_pkg::SIDE_LEFT;
                        st_next.failure_kind  = ocs_pkg::OP_NONE;
                        st_next.retry_left    = 8'd0;
                        st_next.retry_right   = 8'd0;
                        st_next.grip_low_seen = 1'b0;
                        wait_start_next       = '0;
                    end
                end
                ocs_pkg::ST_MANUAL: begin
                    if (op != ocs_pkg::OP_DISC && grip_closed) begin
                        if (op == ocs_pkg::OP_REGRIP && st_cur.side == ocs_pkg::SIDE_LEFT) begin
                            st_next.retry_left = 8'd0;
                        end
                        if (op == ocs_pkg::OP_REGRIP && st_cur.side == ocs_pkg::SIDE_RIGHT) begin
                            st_next.retry_right = 8'd0;
                        end
                        st_next.failure_kind  = ocs_pkg::OP_NONE;
                        acts.reset_disconnect = 1'b1;
                        if (op == ocs_pkg::OP_CLOSE) begin
                            st_next.stage   = ocs_pkg::ST_OPEN;
                            wait_start_next = now_time;
                        end else if (st_cur.side == st_cur.first_side) begin
                            st_next.latched_gravity = 2'd0;
                            st_next.side            = opp;
                            st_next.stage           = ocs_pkg::ST_OPEN;
                            wait_start_next         = now_time;
                        end else if (st_cur.side != ocs_pkg::SIDE_NONE) begin
                            st_next.latched_gravity = 2'd0;
                            st_next.stage           = ocs_pkg::ST_CLEAR;
                            st_next.side            = ocs_pkg::SIDE_NONE;
                            acts.wheel_travel_clear = 1'b1;
                        end else begin
                            // full sequencer reset, grip is high here
                            acts.planner_cmd          = ocs_pkg::PACT_SAFETY;
                            acts.reset_remote_session = 1'b1;
                            st_next.latched_gravity   = 2'd0;
                            st_next.stage             = ocs_pkg::ST_IDLE;
                            st_next.side              = ocs_pkg::SIDE_NONE;
                            st_next.first_side        = ocs_pkg::SIDE_LEFT;
                            st_next.retry_left        = 8'd0;
                            st_next.retry_right       = 8'd0;
                            st_next.grip_low_seen     = 1'b0;
                            wait_start_next           = '0;
                        end
                    end
                end
                default: begin
                end
            endcase

            // gravity latch follows the side while the side is being crossed
            if (st_next.stage >= ocs_pkg::ST_ENABLE && st_next.stage <= ocs_pkg::ST_REOPEN) begin
                need_latch = 1'b1;
            end else if (st_next.stage == ocs_pkg::ST_MANUAL) begin
                need_latch = st_next.failure_kind != ocs_pkg::OP_NONE &&
                             st_next.failure_kind != ocs_pkg::OP_CLOSE;
            end
            if (need_latch && st_next.side == ocs_pkg::SIDE_LEFT) begin
                st_next.latched_gravity = cfg.left_gravity_mode;
            end else if (need_latch && st_next.side == ocs_pkg::SIDE_RIGHT) begin
                st_next.latched_gravity = cfg.right_gravity_mode;
            end
        end
    end

endmodule

`default_nettype wire
